// ===== src/atu_pkg.sv =====
package atu_pkg;

  // Entry count and derived widths
  localparam int ENTRIES  = 64;
  localparam int IDX_W    = $clog2(ENTRIES);
  localparam int HIT_W    = 7;
  localparam int IN_DW    = 80;
  localparam int OUT_DW   = 120;
  localparam int ADDR_W   = 5;
  localparam logic [31:0] BASE_MASK = 32'hfffffc00;

  // Request codes as they arrive on the input channel
  typedef enum logic [2:0] {
    REQ_LOAD  = 3'd0,
    REQ_STORE = 3'd1,
    REQ_FETCH = 3'd2,
    REQ_WR_HI = 3'd3,
    REQ_WR_LO = 3'd4,
    REQ_READ  = 3'd5,
    REQ_INVAL = 3'd6
  } req_t;

  // What the back end has to do with a queued transaction
  typedef enum logic [2:0] {
    OP_XLATE,
    OP_PASS,
    OP_WR_HI,
    OP_WR_LO,
    OP_READ,
    OP_INVAL,
    OP_NOP
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_MISS   = 2'd1,
    ST_ZONE   = 2'd2,
    ST_DENIED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOOK,
    BK_RESP
  } bk_state_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_PID   = 3'd0,
    REG_ZONE  = 3'd1,
    REG_DXLAT = 3'd2,
    REG_IXLAT = 3'd3,
    REG_PSTATE = 3'd4
  } reg_idx_t;

  typedef struct packed {
    op_t         op;
    logic [2:0]  req;
    logic [31:0] ea;
    logic [IDX_W-1:0] sel;
    logic [31:0] word;
    logic [7:0]  tid;
  } item_t;

  typedef struct packed {
    logic [7:0]  pid;
    logic [31:0] zone;
    logic        pstate;
  } prot_cfg_t;

  // Page mask from a hi word: 1 KiB times four to the size field
  function automatic logic [31:0] page_mask(input logic [31:0] hi);
    logic [4:0] sh;
    sh = {1'b0, hi[9:7], 1'b0};
    return BASE_MASK << sh;
  endfunction

endpackage

// ===== src/atu_front.sv =====
module atu_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // virt_addr, entry_index, write_word, entry_tid, zero pad
  input  logic [atu_pkg::IN_DW-1:0]     in_tdata,
  // req_type
  input  logic [2:0]                    in_tuser,
  input  logic                          dxlat,
  input  logic                          ixlat,
  output logic                          q_valid,
  output atu_pkg::item_t                q_item,
  input  logic                          q_pop
);

  atu_pkg::item_t item;
  atu_pkg::item_t fifo_r [2];
  logic           wptr_r, wptr_nxt;
  logic           rptr_r, rptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push;

  // Classify the incoming transaction
  always_comb begin
    item.req  = in_tuser;
    item.ea   = in_tdata[31:0];
    item.sel  = in_tdata[32 +: atu_pkg::IDX_W];
    item.word = in_tdata[69:38];
    item.tid  = in_tdata[77:70];
    case (in_tuser)
      atu_pkg::REQ_LOAD, atu_pkg::REQ_STORE: begin
        item.op = dxlat ? atu_pkg::OP_XLATE : atu_pkg::OP_PASS;
      end
      atu_pkg::REQ_FETCH: begin
        item.op = ixlat ? atu_pkg::OP_XLATE : atu_pkg::OP_PASS;
      end
      atu_pkg::REQ_WR_HI: item.op = atu_pkg::OP_WR_HI;
      atu_pkg::REQ_WR_LO: item.op = atu_pkg::OP_WR_LO;
      atu_pkg::REQ_READ:  item.op = atu_pkg::OP_READ;
      atu_pkg::REQ_INVAL: item.op = atu_pkg::OP_INVAL;
      default:            item.op = atu_pkg::OP_NOP;
    endcase
  end

  // Two-deep queue towards the back end
  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = fifo_r[rptr_r];

  always_comb begin
    wptr_nxt = push  ? ~wptr_r : wptr_r;
    rptr_nxt = q_pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wptr_r] <= item;
    end
  end

endmodule

// ===== src/atu_back.sv =====
module atu_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  atu_pkg::item_t              q_item,
  output logic                        q_pop,
  input  atu_pkg::prot_cfg_t          cfg,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // status, phys_addr, little_endian, hit_index, read_hi, read_lo, read_tid, pad
  output logic [atu_pkg::OUT_DW-1:0]  out_tdata
);

  localparam int N = atu_pkg::ENTRIES;
  localparam int W = atu_pkg::IDX_W;

  atu_pkg::bk_state_t state_r, state_nxt;
  atu_pkg::item_t     cur_r, cur_nxt;

  // Tag side of the entries, compared in parallel
  logic [31:0]  hi_r  [N];
  logic [7:0]   tag_r [N];
  // mr_r[j][i] set means entry j was hit more recently than entry i
  logic [N-1:0] mr_r  [N];
  // Lo words live in a memory with a written flag per entry
  logic [31:0]  lo_mem [N];
  logic [N-1:0] lo_vld_r;

  logic [N-1:0]  match, win;
  logic          found;
  logic [W-1:0]  win_idx;
  logic [W-1:0]  idx;
  logic          look;
  logic          do_hit;
  logic [W-1:0]  lo_raddr;
  logic [31:0]   lo_q;
  logic          lo_q_vld;
  logic          found_r;
  logic [W-1:0]  idx_r;
  logic [31:0]   hi_q_r;
  logic [7:0]    tag_q_r;

  logic [31:0]   lo_word, mask, zshift, pa;
  logic [4:0]    zsh;
  logic [1:0]    zone, st;
  logic          perm, le;
  logic [6:0]    hit_out;
  logic [31:0]   rhi, rlo;
  logic [7:0]    rtid;
  logic          out_free, load_out;
  logic          out_tvalid_r;
  logic [atu_pkg::OUT_DW-1:0] out_data_r;

  // Parallel compare over all entries
  always_comb begin
    logic [31:0] m;
    for (int i = 0; i < N; i++) begin
      m = atu_pkg::page_mask(hi_r[i]);
      match[i] = hi_r[i][6] && (((cur_r.ea ^ hi_r[i]) & m) == 32'd0) &&
                 (tag_r[i] == 8'd0 || tag_r[i] == cfg.pid);
    end
  end

  // A match wins when no other matching entry is more recent
  always_comb begin
    for (int i = 0; i < N; i++) begin
      logic beaten;
      beaten = 1'b0;
      for (int j = 0; j < N; j++) begin
        beaten = beaten | (match[j] & mr_r[j][i]);
      end
      win[i] = match[i] & ~beaten;
    end
    found   = |match;
    win_idx = '0;
    for (int i = 0; i < N; i++) begin
      win_idx = win_idx | (win[i] ? W'(i) : '0);
    end
  end

  assign look     = (state_r == atu_pkg::BK_LOOK);
  assign do_hit   = look && cur_r.op == atu_pkg::OP_XLATE && found;
  assign idx      = (cur_r.op == atu_pkg::OP_XLATE) ? win_idx : cur_r.sel;
  assign lo_raddr = idx;

  // Entry state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) begin
        hi_r[i]  <= '0;
        tag_r[i] <= '0;
        for (int j = 0; j < N; j++) begin
          mr_r[i][j] <= (i < j);
        end
      end
      lo_vld_r <= '0;
    end else if (look) begin
      case (cur_r.op)
        atu_pkg::OP_WR_HI: begin
          hi_r[cur_r.sel]  <= cur_r.word;
          tag_r[cur_r.sel] <= cur_r.tid;
        end
        atu_pkg::OP_WR_LO: lo_vld_r[cur_r.sel] <= 1'b1;
        atu_pkg::OP_INVAL: begin
          for (int i = 0; i < N; i++) begin
            hi_r[i][6] <= 1'b0;
          end
        end
        atu_pkg::OP_XLATE: begin
          if (found) begin
            for (int j = 0; j < N; j++) begin
              if (j != int'(win_idx)) begin
                mr_r[win_idx][j] <= 1'b1;
                mr_r[j][win_idx] <= 1'b0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Lo word memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (look && cur_r.op == atu_pkg::OP_WR_LO) begin
      lo_mem[cur_r.sel] <= cur_r.word;
    end
    lo_q     <= lo_mem[lo_raddr];
    lo_q_vld <= lo_vld_r[lo_raddr];
  end

  // Lookup results held for the response cycle
  always_ff @(posedge clk) begin
    if (look) begin
      found_r <= found && do_hit;
      idx_r   <= idx;
      hi_q_r  <= hi_r[idx];
      tag_q_r <= tag_r[idx];
    end
  end

  // Protection check and result assembly
  always_comb begin
    lo_word = lo_q_vld ? lo_q : 32'd0;
    mask    = atu_pkg::page_mask(hi_q_r);
    zsh     = 5'd30 - {lo_word[7:4], 1'b0};
    zshift  = cfg.zone >> zsh;
    zone    = zshift[1:0];
    perm    = (cur_r.req == atu_pkg::REQ_STORE) ? lo_word[8] : lo_word[9];
    st      = atu_pkg::ST_OK;
    pa      = 32'd0;
    le      = 1'b0;
    hit_out = 7'(N);
    rhi     = 32'd0;
    rlo     = 32'd0;
    rtid    = 8'd0;
    case (cur_r.op)
      atu_pkg::OP_PASS: pa = cur_r.ea;
      atu_pkg::OP_XLATE: begin
        if (!found_r) begin
          st = atu_pkg::ST_MISS;
        end else begin
          hit_out = 7'(idx_r);
          if (cur_r.req == atu_pkg::REQ_LOAD) begin
            if (cfg.pstate && zone == 2'd0) st = atu_pkg::ST_ZONE;
          end else if (cfg.pstate) begin
            if (zone == 2'd0) st = atu_pkg::ST_ZONE;
            else if (zone != 2'd3 && !perm) st = atu_pkg::ST_DENIED;
          end else begin
            if (zone <= 2'd1 && !perm) st = atu_pkg::ST_DENIED;
          end
          if (st == atu_pkg::ST_OK) begin
            pa = (cur_r.ea & ~mask) | (lo_word & mask);
            le = hi_q_r[5];
          end
        end
      end
      atu_pkg::OP_READ: begin
        rhi  = hi_q_r;
        rlo  = lo_word;
        rtid = tag_q_r;
      end
      default: ;
    endcase
  end

  // Sequencer: take, look up, respond
  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    q_pop     = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      atu_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cur_nxt   = q_item;
          state_nxt = atu_pkg::BK_LOOK;
        end
      end
      atu_pkg::BK_LOOK: state_nxt = atu_pkg::BK_RESP;
      atu_pkg::BK_RESP: begin
        if (out_free) begin
          load_out = 1'b1;
          if (q_valid) begin
            q_pop     = 1'b1;
            cur_nxt   = q_item;
            state_nxt = atu_pkg::BK_LOOK;
          end else begin
            state_nxt = atu_pkg::BK_IDLE;
          end
        end
      end
      default: state_nxt = atu_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= atu_pkg::BK_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (load_out) begin
      out_data_r <= {6'd0, rtid, rlo, rhi, hit_out, le, pa, st};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== src/tlb_address_translation_unit.sv =====
// Fully associative 64-entry address translation buffer with zone protection.
// Input channel in_*: in_tuser carries the request code (load, store, fetch,
// write hi, write lo, read entry, invalidate all); in_tdata carries the
// address, entry number, write word and TID. Every transaction gives exactly
// one result transaction on out_*, in order.
// Configuration goes through the cfg_* APB-style port, one register per
// word: process ID, zone protection, data and instruction translation enable
// and problem state. Write it only while no transaction is outstanding.
// A transaction passes through the input queue, the parallel tag compare with
// recency update and lo-word memory read, and the protection check before the
// result register. The back end takes a new transaction only when the result
// of the previous one is loaded into the result register, so it never works on
// two transactions at once.
// A stalled result stays in the output register; the two-deep input queue
// keeps accepting until full. Reset clears all entries to invalid, the
// recency order to entry 0 first, and the control and configuration registers to zero; data registers are not reset.
module tlb_address_translation_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // virt_addr[31:0], entry_index[37:32], write_word[69:38], entry_tid[77:70]
  input  logic [atu_pkg::IN_DW-1:0]     in_tdata,
  // req_type[2:0]
  input  logic [2:0]                    in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // status[1:0], phys_addr[33:2], little_endian[34], hit_index[41:35],
  // read_hi[73:42], read_lo[105:74], read_tid[113:106]
  output logic [atu_pkg::OUT_DW-1:0]    out_tdata,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [atu_pkg::ADDR_W-1:0]    cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  logic [7:0]  pid_r;
  logic [31:0] zone_r;
  logic        dxlat_r, ixlat_r, pstate_r;
  logic        wr_en;
  logic [2:0]  reg_idx;
  logic        q_valid, q_pop;
  atu_pkg::item_t     q_item;
  atu_pkg::prot_cfg_t cfg;

  // Register file
  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pid_r    <= '0;
      zone_r   <= '0;
      dxlat_r  <= 1'b0;
      ixlat_r  <= 1'b0;
      pstate_r <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        atu_pkg::REG_PID:    pid_r    <= cfg_pwdata[7:0];
        atu_pkg::REG_ZONE:   zone_r   <= cfg_pwdata;
        atu_pkg::REG_DXLAT:  dxlat_r  <= cfg_pwdata[0];
        atu_pkg::REG_IXLAT:  ixlat_r  <= cfg_pwdata[0];
        atu_pkg::REG_PSTATE: pstate_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      atu_pkg::REG_PID:    cfg_prdata = {24'd0, pid_r};
      atu_pkg::REG_ZONE:   cfg_prdata = zone_r;
      atu_pkg::REG_DXLAT:  cfg_prdata = {31'd0, dxlat_r};
      atu_pkg::REG_IXLAT:  cfg_prdata = {31'd0, ixlat_r};
      atu_pkg::REG_PSTATE: cfg_prdata = {31'd0, pstate_r};
      default:             cfg_prdata = 32'd0;
    endcase
  end

  assign cfg.pid    = pid_r;
  assign cfg.zone   = zone_r;
  assign cfg.pstate = pstate_r;

  atu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .dxlat     (dxlat_r),
    .ixlat     (ixlat_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  atu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .cfg        (cfg),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== verif/tlb_address_translation_unit_test.sv =====
`timescale 1ns / 100ps

module tlb_address_translation_unit_test;

  localparam int PERIOD = 10;

  // Directed table row: request plus an optional typed-in expectation
  typedef struct {
    atu_pkg::req_t    req;
    logic [31:0]      ea;
    logic [5:0]       sel;
    logic [31:0]      word;
    logic [7:0]       tid;
    bit               fixed;
    atu_pkg::status_t st;
    logic [31:0]      pa;
    logic [6:0]       hit;
  } row_t;

  typedef struct packed {
    logic [7:0]  rtid;
    logic [31:0] rlo;
    logic [31:0] rhi;
    logic [6:0]  hit;
    logic        le;
    logic [31:0] pa;
    logic [1:0]  st;
  } xlate_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [atu_pkg::IN_DW-1:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [atu_pkg::OUT_DW-1:0] out_tdata;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [atu_pkg::ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  // Shadow copy of the buffer contents and the protection registers
  logic [31:0] tlb_hi [atu_pkg::ENTRIES];
  logic [31:0] tlb_lo [atu_pkg::ENTRIES];
  logic [7:0]  tlb_tid [atu_pkg::ENTRIES];
  int          mru_order [atu_pkg::ENTRIES];
  logic [7:0]  cur_pid;
  logic [31:0] cur_zone;
  logic        cur_dxlat, cur_ixlat, cur_pstate;

  xlate_result_t pending_results [$];
  int  mismatches = 0;
  bit  sink_hold = 1'b0;
  bit  idle_free = 1'b0;
  row_t dir_rows [$];

  always #(PERIOD / 2) clk = ~clk;

  tlb_address_translation_unit dut (.*);

  task automatic report_mismatch(input string what, input logic [127:0] got,
                                 input logic [127:0] want);
    mismatches++;
    $display("mismatch %0s: got %0h expected %0h", what, got, want);
  endtask

  function automatic bit entry_hits(int i, logic [31:0] ea);
    logic [31:0] m;
    m = atu_pkg::BASE_MASK << (2 * tlb_hi[i][9:7]);
    return tlb_hi[i][6] && ((ea & m) == (tlb_hi[i] & m)) &&
           (tlb_tid[i] == 0 || tlb_tid[i] == cur_pid);
  endfunction

  // Work out the result of one transaction and update the shadow state
  function automatic xlate_result_t translate(atu_pkg::req_t req, logic [31:0] ea,
      logic [5:0] sel, logic [31:0] word, logic [7:0] tid);
    xlate_result_t r;
    int hit, idx;
    logic [31:0] lo, m;
    logic [1:0] zone;
    bit perm;
    r = '0;
    r.hit = 7'(atu_pkg::ENTRIES);
    if (req == atu_pkg::REQ_LOAD || req == atu_pkg::REQ_STORE ||
        req == atu_pkg::REQ_FETCH) begin
      if (!(req == atu_pkg::REQ_FETCH ? cur_ixlat : cur_dxlat)) begin
        r.pa = ea;
      end else begin
        hit = atu_pkg::ENTRIES;
        for (int k = 0; k < atu_pkg::ENTRIES; k++) begin
          idx = mru_order[k];
          if (entry_hits(idx, ea)) begin
            for (int j = k; j > 0; j--) mru_order[j] = mru_order[j - 1];
            mru_order[0] = idx;
            hit = idx;
            break;
          end
        end
        r.hit = 7'(hit);
        if (hit == atu_pkg::ENTRIES) begin
          r.st = atu_pkg::ST_MISS;
        end else begin
          lo = tlb_lo[hit];
          zone = cur_zone[30 - 2 * lo[7:4] +: 2];
          perm = (req == atu_pkg::REQ_STORE) ? lo[8] : lo[9];
          if (req == atu_pkg::REQ_LOAD) begin
            if (cur_pstate && zone == 0) r.st = atu_pkg::ST_ZONE;
          end else if (cur_pstate) begin
            if (zone == 0) r.st = atu_pkg::ST_ZONE;
            else if (zone != 3 && !perm) r.st = atu_pkg::ST_DENIED;
          end else if (zone <= 1 && !perm) begin
            r.st = atu_pkg::ST_DENIED;
          end
          if (r.st == atu_pkg::ST_OK) begin
            m = atu_pkg::BASE_MASK << (2 * tlb_hi[hit][9:7]);
            r.pa = (ea & ~m) | (lo & m);
            r.le = tlb_hi[hit][5];
          end
        end
      end
    end else if (req == atu_pkg::REQ_WR_HI) begin
      tlb_hi[sel] = word;
      tlb_tid[sel] = tid;
    end else if (req == atu_pkg::REQ_WR_LO) begin
      tlb_lo[sel] = word;
    end else if (req == atu_pkg::REQ_READ) begin
      r.rhi = tlb_hi[sel];
      r.rlo = tlb_lo[sel];
      r.rtid = tlb_tid[sel];
    end else if (req == atu_pkg::REQ_INVAL) begin
      for (int i = 0; i < atu_pkg::ENTRIES; i++) tlb_hi[i][6] = 1'b0;
    end
    return r;
  endfunction

  // Offer one transaction, with random idle cycles ahead of it
  task automatic send_request(input logic [2:0] req, input logic [31:0] ea,
      input logic [5:0] sel, input logic [31:0] word, input logic [7:0] tid);
    while (!idle_free && $urandom_range(99) < 31) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= {2'b0, tid, word, sel, ea};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(translate(atu_pkg::req_t'(req), ea, sel, word, tid));
  endtask

  task automatic write_reg(input atu_pkg::reg_idx_t idx, input logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= atu_pkg::ADDR_W'(4 * idx);
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      atu_pkg::REG_PID:   cur_pid = value[7:0];
      atu_pkg::REG_ZONE:  cur_zone = value;
      atu_pkg::REG_DXLAT: cur_dxlat = value[0];
      atu_pkg::REG_IXLAT: cur_ixlat = value[0];
      default:            cur_pstate = value[0];
    endcase
  endtask

  // Every item gives a result, so idle means the expectation store is empty
  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  function automatic row_t mk(atu_pkg::req_t req, logic [31:0] ea, logic [5:0] sel,
      logic [31:0] word, logic [7:0] tid);
    row_t r;
    r = '{req, ea, sel, word, tid, 1'b0, atu_pkg::ST_OK, '0, '0};
    return r;
  endfunction

  function automatic row_t mkx(atu_pkg::req_t req, logic [31:0] ea,
      atu_pkg::status_t st, logic [31:0] pa, logic [6:0] hit);
    row_t r;
    r = '{req, ea, '0, '0, '0, 1'b1, st, pa, hit};
    return r;
  endfunction

  // A random, mostly well-formed hi word near a small set of pages
  function automatic logic [31:0] rand_hi();
    logic [31:0] w;
    w = $urandom;
    w[31:24] = 8'($urandom_range(3));
    if ($urandom_range(3) != 0) w[9:7] = 3'($urandom_range(2));
    w[6] = ($urandom_range(7) != 0);
    return w;
  endfunction

  function automatic logic [31:0] rand_ea();
    logic [31:0] a;
    a = $urandom;
    if ($urandom_range(7) != 0) a[31:24] = 8'($urandom_range(3));
    return a;
  endfunction

  // Result side: random back-pressure and checking in order
  initial begin
    xlate_result_t got, want;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got = out_tdata[$bits(xlate_result_t)-1:0];
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected transaction", 128'(got), 128'(0));
        end else begin
          want = pending_results.pop_front();
          if (got.st !== want.st)
            report_mismatch("status", 128'(got.st), 128'(want.st));
          if (got.pa !== want.pa)
            report_mismatch("phys_addr", 128'(got.pa), 128'(want.pa));
          if (got.le !== want.le)
            report_mismatch("little_endian", 128'(got.le), 128'(want.le));
          if (got.hit !== want.hit)
            report_mismatch("hit_index", 128'(got.hit), 128'(want.hit));
          if (got.rhi !== want.rhi)
            report_mismatch("read_hi", 128'(got.rhi), 128'(want.rhi));
          if (got.rlo !== want.rlo)
            report_mismatch("read_lo", 128'(got.rlo), 128'(want.rlo));
          if (got.rtid !== want.rtid)
            report_mismatch("read_tid", 128'(got.rtid), 128'(want.rtid));
        end
      end
      if (sink_hold) out_tready <= 1'b0;
      else out_tready <= idle_free || ($urandom_range(99) >= 31);
    end
  end

  initial begin
    #(PERIOD * 400000);
    $display("tlb_address_translation_unit test failed");
    $finish;
  end

  initial begin
    logic [31:0] cfgv;
    row_t row;
    xlate_result_t want;
    int req, n;

    cur_pid = 0; cur_zone = 0; cur_dxlat = 0; cur_ixlat = 0; cur_pstate = 0;
    for (int i = 0; i < atu_pkg::ENTRIES; i++) begin
      tlb_hi[i] = 0; tlb_lo[i] = 0; tlb_tid[i] = 0; mru_order[i] = i;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Translation off passes the address through; reset contents read zero
    dir_rows.push_back(mkx(atu_pkg::REQ_LOAD, 32'hffffffff, atu_pkg::ST_OK, 32'hffffffff,
                           7'(atu_pkg::ENTRIES)));
    dir_rows.push_back(mkx(atu_pkg::REQ_FETCH, 32'h0, atu_pkg::ST_OK, 32'h0,
                           7'(atu_pkg::ENTRIES)));
    dir_rows.push_back(mk(atu_pkg::REQ_READ, 0, 6'd63, 0, 0));
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_request(row.req, row.ea, row.sel, row.word, row.tid);
      if (row.fixed) begin
        want = '0; want.st = row.st; want.pa = row.pa; want.hit = row.hit;
        pending_results[$] = want;
      end
    end
    drain();

    // Everything on, user mode; the zone register sets zones 0..3, of which the entries here use zones 0 and 3
    write_reg(atu_pkg::REG_DXLAT, 1);
    write_reg(atu_pkg::REG_IXLAT, 1);
    write_reg(atu_pkg::REG_PSTATE, 1);
    write_reg(atu_pkg::REG_ZONE, 32'h1b1b1b1b);
    write_reg(atu_pkg::REG_PID, 32'hff);
    dir_rows.delete();
    dir_rows.push_back(mkx(atu_pkg::REQ_LOAD, 32'h1234, atu_pkg::ST_MISS, 0,
                           7'(atu_pkg::ENTRIES)));
    dir_rows.push_back(mk(atu_pkg::REQ_WR_HI, 0, 6'd0, 32'h00000040, 8'h00));
    dir_rows.push_back(mk(atu_pkg::REQ_WR_LO, 0, 6'd0, 32'hfffffc00, 0));
    dir_rows.push_back(mk(atu_pkg::REQ_WR_HI, 0, 6'd63, 32'hffffffe0 | 32'h40, 8'hff));
    dir_rows.push_back(mk(atu_pkg::REQ_WR_LO, 0, 6'd63, 32'h00000330, 0));
    dir_rows.push_back(mk(atu_pkg::REQ_WR_HI, 0, 6'd5, 32'h000003c0, 8'h12));
    dir_rows.push_back(mk(atu_pkg::REQ_WR_LO, 0, 6'd5, 32'h000000f0, 0));
    dir_rows.push_back(mk(atu_pkg::REQ_LOAD, 32'h000003ff, 0, 0, 0));
    dir_rows.push_back(mk(atu_pkg::REQ_STORE, 32'h00000000, 0, 0, 0));
    dir_rows.push_back(mk(atu_pkg::REQ_FETCH, 32'hfffffc55, 0, 0, 0));
    dir_rows.push_back(mk(atu_pkg::REQ_STORE, 32'hffffffff, 0, 0, 0));
    dir_rows.push_back(mk(atu_pkg::REQ_READ, 0, 6'd63, 0, 0));
    dir_rows.push_back(mk(atu_pkg::REQ_INVAL, 0, 0, 0, 0));
    dir_rows.push_back(mk(atu_pkg::req_t'(3'd7), 32'hffffffff, 6'd63, 32'hffffffff, 8'hff));
    dir_rows.push_back(mkx(atu_pkg::REQ_LOAD, 32'h0, atu_pkg::ST_MISS, 0,
                           7'(atu_pkg::ENTRIES)));
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_request(row.req, row.ea, row.sel, row.word, row.tid);
      if (row.fixed) begin
        want = '0; want.st = row.st; want.pa = row.pa; want.hit = row.hit;
        if (want !== pending_results[$])
          report_mismatch("table", 128'(want), 128'(pending_results[$]));
      end
    end
    drain();

    // Random phases, each under its own configuration
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(atu_pkg::REG_PID,
                ph == 1 ? 32'h00 : (ph == 2 ? 32'hff : 32'($urandom_range(3))));
      cfgv = (ph == 1) ? 32'h0 : ((ph == 2) ? 32'hffffffff : $urandom);
      write_reg(atu_pkg::REG_ZONE, cfgv);
      write_reg(atu_pkg::REG_DXLAT, 32'(ph != 3));
      write_reg(atu_pkg::REG_IXLAT, 32'(ph != 4));
      write_reg(atu_pkg::REG_PSTATE, 32'(ph[0]));
      idle_free = (ph == 5);
      // Fill a good part of the buffer first so that lookups mostly hit
      for (int i = 0; i < 24; i++) begin
        n = $urandom_range(63);
        send_request(atu_pkg::REQ_WR_HI, 0, 6'(n), rand_hi(), 8'($urandom_range(3)));
        send_request(atu_pkg::REQ_WR_LO, 0, 6'(n), $urandom, 0);
      end
      if (ph == 6) begin
        // Hold the receiver off while the sender keeps offering
        fork
          begin
            sink_hold = 1'b1;
            repeat (60) @(posedge clk);
            sink_hold = 1'b0;
          end
          repeat (10) send_request(atu_pkg::REQ_LOAD, rand_ea(), 0, 0, 0);
        join
      end
      for (int i = 0; i < 130; i++) begin
        req = $urandom_range(99);
        n = $urandom_range(63);
        if (req < 70)
          send_request(3'(req % 3), rand_ea(), 6'(n), $urandom, 8'($urandom));
        else if (req < 80)
          send_request(atu_pkg::REQ_WR_HI, $urandom, 6'(n), rand_hi(),
                       8'($urandom_range(3)));
        else if (req < 90)
          send_request(atu_pkg::REQ_WR_LO, $urandom, 6'(n), $urandom, 8'($urandom));
        else if (req < 97)
          send_request(atu_pkg::REQ_READ, $urandom, 6'(n), $urandom, 8'($urandom));
        else if (req < 98)
          send_request(atu_pkg::REQ_INVAL, $urandom, 6'(n), $urandom, 8'($urandom));
        else
          send_request(3'd7, $urandom, 6'(n), $urandom, 8'($urandom));
      end
      drain();
    end
    idle_free = 1'b0;

    drain();
    if (mismatches == 0) begin
      $display("tlb_address_translation_unit test passed");
    end else begin
      $display("tlb_address_translation_unit test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/atu_pkg.sv
src/atu_front.sv
src/atu_back.sv
src/tlb_address_translation_unit.sv
verif/tlb_address_translation_unit_test.sv
